>>> design/sfd_pkg.sv
// shared types and constants for the stereo fractional delay
package sfd_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int FRAC_BITS = 16;
    localparam int DELAY_W   = 30;

    typedef enum logic [0:0]
    {
        REG_DELAY_LEFT  = 1'b0,
        REG_DELAY_RIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic                       last_in_block;
    } in_beat_t;

    typedef struct packed
    {
        logic signed [SAMPLE_W-1:0] left_delayed;
        logic signed [SAMPLE_W-1:0] right_delayed;
        logic                       block_end;
    } out_beat_t;

endpackage

>>> design/sfd_channel.sv
// one channel: ring memory, fractional read address and linear interpolation
module sfd_channel
    import sfd_pkg::*;
#(
    parameter int RING_DEPTH = 16384
)
(
    input  logic                                clk,
    input  logic                                accept,
    input  logic [$clog2(RING_DEPTH)-1:0]       wr_ptr,
    input  logic                                ring_full,
    input  logic [DELAY_W-1:0]                  delay,
    input  logic signed [SAMPLE_W-1:0]          sample,
    output logic signed [SAMPLE_W-1:0]          result
);

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int PW    = AW + FRAC_BITS + 1;
    localparam int XW    = (PW > DELAY_W) ? PW : DELAY_W;
    localparam int PRODW = SAMPLE_W + FRAC_BITS + 2;

    localparam logic [XW-1:0] DELAY_MAX = XW'(RING_DEPTH - 4) << FRAC_BITS;
    localparam logic [PW-1:0] SPAN      = PW'(RING_DEPTH) << FRAC_BITS;
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

    logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];

    // address generation
    logic [XW-1:0]        d_ext;
    logic [XW-1:0]        d_clamp;
    logic [PW-1:0]        pos_raw;
    logic [PW-1:0]        pos;
    logic [AW-1:0]        ia;
    logic [AW-1:0]        ib;
    logic [FRAC_BITS-1:0] frac;

    always_comb
    begin
        d_ext   = XW'(delay);
        d_clamp = (d_ext > DELAY_MAX) ? DELAY_MAX : d_ext;
        pos_raw = {1'b0, wr_ptr, {FRAC_BITS{1'b0}}} + SPAN - d_clamp[PW-1:0];
        pos     = (pos_raw >= SPAN) ? (pos_raw - SPAN) : pos_raw;
        ia      = pos[AW+FRAC_BITS-1:FRAC_BITS];
        frac    = pos[FRAC_BITS-1:0];
        ib      = (ia == LAST_SLOT) ? '0 : (ia + 1'b1);
    end

    // stage 1: read data and forwarding flags
    logic signed [SAMPLE_W-1:0] rd_a_reg;
    logic signed [SAMPLE_W-1:0] rd_b_reg;
    logic signed [SAMPLE_W-1:0] samp1_reg;
    logic [FRAC_BITS-1:0]       frac1_reg;
    logic                       a_fwd1_reg;
    logic                       a_ok1_reg;
    logic                       b_fwd1_reg;
    logic                       b_ok1_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_mem[wr_ptr] <= sample;
        end
        rd_a_reg <= ring_mem[ia];
        rd_b_reg <= ring_mem[ib];
    end

    // slots beyond the fill point have never been written and read as zero
    always_ff @(posedge clk)
    begin
        samp1_reg  <= sample;
        frac1_reg  <= frac;
        a_fwd1_reg <= (ia == wr_ptr);
        a_ok1_reg  <= ring_full || (ia < wr_ptr);
        b_fwd1_reg <= (ib == wr_ptr);
        b_ok1_reg  <= ring_full || (ib < wr_ptr);
    end

    logic signed [SAMPLE_W-1:0] a_sel;
    logic signed [SAMPLE_W-1:0] b_sel;
    logic signed [SAMPLE_W:0]   diff_next;

    always_comb
    begin
        if (a_fwd1_reg)
        begin
            a_sel = samp1_reg;
        end
        else if (a_ok1_reg)
        begin
            a_sel = rd_a_reg;
        end
        else
        begin
            a_sel = '0;
        end
        if (b_fwd1_reg)
        begin
            b_sel = samp1_reg;
        end
        else if (b_ok1_reg)
        begin
            b_sel = rd_b_reg;
        end
        else
        begin
            b_sel = '0;
        end
        diff_next = (SAMPLE_W+1)'(b_sel) - (SAMPLE_W+1)'(a_sel);
    end

    // stage 2: selected sample and difference
    logic signed [SAMPLE_W-1:0] a2_reg;
    logic signed [SAMPLE_W:0]   diff2_reg;
    logic [FRAC_BITS-1:0]       frac2_reg;

    always_ff @(posedge clk)
    begin
        a2_reg    <= a_sel;
        diff2_reg <= diff_next;
        frac2_reg <= frac1_reg;
    end

    // stage 3: product
    logic signed [PRODW-1:0]    prod_next;
    logic signed [PRODW-1:0]    prod3_reg;
    logic signed [SAMPLE_W-1:0] a3_reg;

    assign prod_next = diff2_reg * $signed({1'b0, frac2_reg});

    always_ff @(posedge clk)
    begin
        prod3_reg <= prod_next;
        a3_reg    <= a2_reg;
    end

    // arithmetic shift floors; the sum stays between a and b so low bits suffice
    logic signed [PRODW-1:0] shifted;

    assign shifted = prod3_reg >>> FRAC_BITS;
    assign result  = a3_reg + shifted[SAMPLE_W-1:0];

endmodule

>>> design/stereo_fractional_delay_top.sv
// stereo fractional delay top: handshakes, write pointer, delay registers, output queue
//
// Each accepted beat writes one stereo pair into the two ring memories and returns
// one beat with both channels read back at their own fractional delay, linearly
// interpolated. One beat is taken every cycle; each result is registered through
// the memory read, difference and multiply stages, then summed and written into the
// output queue, from which it is offered. An 8-entry output queue lets input
// continue while results wait; input stalls only when
// 8 beats are accepted but not yet taken. Ring slots not yet written since reset
// read as zero, tracked by the write pointer and a wrap flag, so no clearing pass
// is needed. Delays are 14.16 samples, clamped to RING_DEPTH-4 when used; write
// them only while the block is idle.
module stereo_fractional_delay_top
    import sfd_pkg::*;
#(
    parameter int RING_DEPTH = 16384
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_beat_t            in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output out_beat_t           out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  cfg_reg_t            cfg_index,
    input  logic [DELAY_W-1:0]  cfg_data
);

    localparam int AW         = $clog2(RING_DEPTH);
    localparam int FIFO_DEPTH = 8;
    localparam int QW         = $clog2(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

    logic accept;
    logic pop;
    logic push;

    // configuration
    logic [DELAY_W-1:0] delay_left_reg;
    logic [DELAY_W-1:0] delay_right_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_left_reg  <= '0;
            delay_right_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DELAY_LEFT:  delay_left_reg  <= cfg_data;
                REG_DELAY_RIGHT: delay_right_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // write pointer and wrap flag
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;
    logic          full_reg;

    assign wp_next = (wp_reg == LAST_SLOT) ? '0 : (wp_reg + 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            full_reg <= 1'b0;
        end
        else if (accept)
        begin
            wp_reg <= wp_next;
            if (wp_reg == LAST_SLOT)
            begin
                full_reg <= 1'b1;
            end
        end
    end

    // channels
    logic signed [SAMPLE_W-1:0] left_y;
    logic signed [SAMPLE_W-1:0] right_y;

    sfd_channel #(
        .RING_DEPTH (RING_DEPTH)
    ) u_left (
        .clk        (clk),
        .accept     (accept),
        .wr_ptr     (wp_reg),
        .ring_full  (full_reg),
        .delay      (delay_left_reg),
        .sample     (in_data.left_sample),
        .result     (left_y)
    );

    sfd_channel #(
        .RING_DEPTH (RING_DEPTH)
    ) u_right (
        .clk        (clk),
        .accept     (accept),
        .wr_ptr     (wp_reg),
        .ring_full  (full_reg),
        .delay      (delay_right_reg),
        .sample     (in_data.right_sample),
        .result     (right_y)
    );

    // valid and block marker follow the channel pipeline
    logic [2:0] v_reg;
    logic [2:0] be_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[1:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        be_reg <= {be_reg[1:0], in_data.last_in_block};
    end

    assign push = v_reg[2];

    // output queue, credit counted from acceptance
    out_beat_t     fifo_mem [FIFO_DEPTH];
    logic [QW-1:0] fifo_wr_reg;
    logic [QW-1:0] fifo_rd_reg;
    logic [QW:0]   fifo_cnt_reg;
    logic [QW:0]   occ_reg;
    out_beat_t     push_beat;

    assign in_ready  = (occ_reg != (QW+1)'(FIFO_DEPTH));
    assign accept    = in_valid && in_ready;
    assign out_valid = (fifo_cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = fifo_mem[fifo_rd_reg];

    always_comb
    begin
        push_beat.left_delayed  = left_y;
        push_beat.right_delayed = right_y;
        push_beat.block_end     = be_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[fifo_wr_reg] <= push_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_wr_reg  <= '0;
            fifo_rd_reg  <= '0;
            fifo_cnt_reg <= '0;
            occ_reg      <= '0;
        end
        else
        begin
            if (push)
            begin
                fifo_wr_reg <= fifo_wr_reg + 1'b1;
            end
            if (pop)
            begin
                fifo_rd_reg <= fifo_rd_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_reg + (QW+1)'(push) - (QW+1)'(pop);
            occ_reg      <= occ_reg + (QW+1)'(accept) - (QW+1)'(pop);
        end
    end

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= (QW+1)'(FIFO_DEPTH))
        else $error("outstanding beat count exceeds queue depth");

    a_queue_le_occ: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= occ_reg)
        else $error("queue holds more beats than were accepted");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_cnt_reg != (QW+1)'(FIFO_DEPTH)))
        else $error("result pushed into full queue");

    a_wrap_sets_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (wp_reg == LAST_SLOT)) |=> (full_reg && (wp_reg == '0)))
        else $error("write pointer wrap not tracked");
`endif

endmodule
